[src/cbf_pkg.sv]
// ----------------------------------------------------------------------------
// cbf_pkg
// Shared constants and codes of the counting Bloom filter.
// ----------------------------------------------------------------------------
`default_nettype none

package cbf_pkg;

	localparam int unsigned ELEMENT_BYTES = 8;
	localparam int unsigned MAX_HASHES    = 4;

	localparam int unsigned OP_W    = 2;
	localparam int unsigned ELEM_W  = 64;
	localparam int unsigned MIN_W   = 8;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 32;
	localparam int unsigned HCNT_W  = 3;
	localparam int unsigned SEED_IDX_W = 2;

	typedef logic [OP_W-1:0]      op_t;
	typedef logic [ELEM_W-1:0]    element_t;
	typedef logic [MIN_W-1:0]     min_count_t;
	typedef logic [CFG_IDX_W-1:0] cfg_index_t;
	typedef logic [CFG_DAT_W-1:0] cfg_data_t;
	typedef logic [HCNT_W-1:0]    hash_count_t;
	typedef logic [31:0]          word_t;

	localparam op_t OP_INSERT = 2'd0;
	localparam op_t OP_REMOVE = 2'd1;
	localparam op_t OP_CHECK  = 2'd2;
	localparam op_t OP_NONE   = 2'd3;

	localparam cfg_index_t REG_HASH_COUNT = 3'd0;
	localparam cfg_index_t REG_SEED_ZERO  = 3'd1;
	localparam cfg_index_t REG_SEED_ONE   = 3'd2;
	localparam cfg_index_t REG_SEED_TWO   = 3'd3;
	localparam cfg_index_t REG_SEED_THREE = 3'd4;

	localparam word_t MUR_C1    = 32'h239b961b;
	localparam word_t MUR_C2    = 32'hab0e9789;
	localparam word_t MUR_C3    = 32'h38b34ae5;
	localparam word_t FMIX_M1   = 32'h85ebca6b;
	localparam word_t FMIX_M2   = 32'hc2b2ae35;
	localparam word_t LEN_WORD  = 32'(ELEMENT_BYTES);
	localparam word_t MIN_START = 32'h7fffffff;

endpackage

`default_nettype wire

[src/cbf_if.sv]
// ----------------------------------------------------------------------------
// cbf_if
// Handshake channels of the counting Bloom filter.
// ----------------------------------------------------------------------------
`default_nettype none

interface cbf_req_if;
	import cbf_pkg::*;
	logic     valid;
	logic     ready;
	op_t      op;
	element_t element;
	modport source (output valid, op, element, input ready);
	modport sink   (input valid, op, element, output ready);
endinterface

interface cbf_rsp_if;
	import cbf_pkg::*;
	logic       valid;
	logic       ready;
	min_count_t min_count;
	logic       present;
	modport source (output valid, min_count, present, input ready);
	modport sink   (input valid, min_count, present, output ready);
endinterface

interface cbf_cfg_if;
	import cbf_pkg::*;
	logic       valid;
	logic       ready;
	cfg_index_t index;
	cfg_data_t  data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[src/cbf_hash.sv]
// ----------------------------------------------------------------------------
// cbf_hash
// MurmurHash3 x86 128 (low 64 bits) of an 8-byte element, reduced to a
// counter index. Four 32-bit lanes, one multiplier each, stepped by a
// sequencer; non power-of-two counts fold the hash to 33 bits and finish
// with a reciprocal multiplication.
// ----------------------------------------------------------------------------
`default_nettype none

module cbf_hash #(
	parameter int unsigned NUM_COUNTERS = 1024
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire cbf_pkg::element_t                 element,
	input  wire cbf_pkg::word_t                    seed,
	output logic                                   done,
	output logic [$clog2(NUM_COUNTERS)-1:0]        index
);
	import cbf_pkg::*;

	localparam int unsigned IDX_W = $clog2(NUM_COUNTERS);
	localparam bit          POW2  = (NUM_COUNTERS & (NUM_COUNTERS - 1)) == 0;
	localparam logic [IDX_W:0] NUM_W = (IDX_W+1)'(NUM_COUNTERS);
	// 2^32 mod N folds the upper word down; floor(2^33 / N) estimates the quotient
	localparam word_t       FOLD_D = 32'((64'd1 << 32) % NUM_COUNTERS);
	localparam word_t       BAR_M  = 32'((64'd1 << 33) / NUM_COUNTERS);
	localparam logic [32:0] NUM_L  = 33'(NUM_COUNTERS);

	typedef enum logic [17:0] {
		H_IDLE = 18'h00001,
		H_K1   = 18'h00002,
		H_K2   = 18'h00004,
		H_H0   = 18'h00008,
		H_H1   = 18'h00010,
		H_H2   = 18'h00020,
		H_M1   = 18'h00040,
		H_M2   = 18'h00080,
		H_FX   = 18'h00100,
		H_S0   = 18'h00200,
		H_S1   = 18'h00400,
		H_S2   = 18'h00800,
		H_F1   = 18'h01000,
		H_F2   = 18'h02000,
		H_F3   = 18'h04000,
		H_BQ   = 18'h08000,
		H_BR   = 18'h10000,
		H_BC   = 18'h20000
	} hstate_t;

	hstate_t           state_q;
	logic              done_q;
	element_t          elem_q;
	word_t             seed_q;
	word_t             k1_q;
	word_t             k2_q;
	word_t             w_q [4];
	logic [52:0]       red_q;
	word_t             quo_q;
	logic [IDX_W:0]    rem_q;
	logic [IDX_W-1:0]  index_q;

	word_t             a_w, b_w, c_w;
	logic [64:0]       bar_prod;
	logic [32:0]       rem_diff;

	assign a_w = seed_q ^ k1_q ^ LEN_WORD;
	assign b_w = seed_q ^ k2_q ^ LEN_WORD;
	assign c_w = seed_q ^ LEN_WORD;

	// quotient estimate is low by at most one, so the remainder stays below 2N
	assign bar_prod = 65'(red_q[32:0]) * 65'(BAR_M);
	assign rem_diff = red_q[32:0] - 33'(quo_q) * NUM_L;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == H_S2 && POW2) || state_q == H_BC;
			unique case (state_q)
				H_IDLE: if (start) state_q <= H_K1;
				H_K1:   state_q <= H_K2;
				H_K2:   state_q <= H_H0;
				H_H0:   state_q <= H_H1;
				H_H1:   state_q <= H_H2;
				H_H2:   state_q <= H_M1;
				H_M1:   state_q <= H_M2;
				H_M2:   state_q <= H_FX;
				H_FX:   state_q <= H_S0;
				H_S0:   state_q <= H_S1;
				H_S1:   state_q <= H_S2;
				H_S2:   state_q <= POW2 ? H_IDLE : H_F1;
				H_F1:   state_q <= H_F2;
				H_F2:   state_q <= H_F3;
				H_F3:   state_q <= H_BQ;
				H_BQ:   state_q <= H_BR;
				H_BR:   state_q <= H_BC;
				H_BC:   state_q <= H_IDLE;
				default: state_q <= H_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			H_IDLE: begin
				elem_q <= element;
				seed_q <= seed;
			end
			H_K1: begin
				k1_q <= elem_q[31:0] * MUR_C1;
				k2_q <= elem_q[63:32] * MUR_C2;
			end
			H_K2: begin
				k1_q <= {k1_q[16:0], k1_q[31:17]} * MUR_C2;
				k2_q <= {k2_q[15:0], k2_q[31:16]} * MUR_C3;
			end
			H_H0: begin
				w_q[0] <= a_w + b_w;
				w_q[1] <= b_w;
				w_q[2] <= c_w + c_w;
				w_q[3] <= c_w;
			end
			H_H1: w_q[0] <= w_q[0] + w_q[2];
			H_H2: begin
				w_q[1] <= w_q[1] + w_q[0];
				w_q[2] <= w_q[3] + w_q[0];
				w_q[3] <= w_q[3] + w_q[0];
			end
			H_M1:
				for (int i = 0; i < 4; i++)
					w_q[i] <= (w_q[i] ^ (w_q[i] >> 16)) * FMIX_M1;
			H_M2:
				for (int i = 0; i < 4; i++)
					w_q[i] <= (w_q[i] ^ (w_q[i] >> 13)) * FMIX_M2;
			H_FX:
				for (int i = 0; i < 4; i++)
					w_q[i] <= w_q[i] ^ (w_q[i] >> 16);
			H_S0: begin
				w_q[0] <= w_q[0] + w_q[1];
				w_q[2] <= w_q[2] + w_q[3];
			end
			H_S1: w_q[0] <= w_q[0] + w_q[2];
			H_S2: begin
				w_q[1]  <= w_q[1] + w_q[0];
				index_q <= w_q[0][IDX_W-1:0];
			end
			// fold bits 32 and up back in: below 2^53, 2^42, then 2^33
			H_F1: red_q <= 53'(w_q[1]) * 53'(FOLD_D) + 53'(w_q[0]);
			H_F2: red_q <= 53'(red_q[52:32]) * 53'(FOLD_D) + 53'(red_q[31:0]);
			H_F3: red_q <= 53'(red_q[41:32]) * 53'(FOLD_D) + 53'(red_q[31:0]);
			H_BQ: quo_q <= bar_prod[64:33];
			H_BR: rem_q <= rem_diff[IDX_W:0];
			H_BC: index_q <= (rem_q >= NUM_W) ? IDX_W'(rem_q - NUM_W) : rem_q[IDX_W-1:0];
			default: ;
		endcase
	end

	assign done  = done_q;
	assign index = index_q;

endmodule

`default_nettype wire

[src/counting_bloom_filter.sv]
// ----------------------------------------------------------------------------
// counting_bloom_filter
// Counting Bloom filter indexed by MurmurHash3; saturating counters in one
// synchronous memory, updated by read-modify-write one seed at a time.
// ----------------------------------------------------------------------------
//  channel  role    word
//  cfg      sink    index, data (register write)
//  req      sink    op, element
//  rsp      source  min_count, present (check only)
//
//  Per seed: the hash (plus the reduction steps when NUM_COUNTERS is not
//  a power of two), the memory read, and a write-back for insert/remove.
//  A new item is accepted only in idle, after every seed of the last one
//  and, for a check, after its result is loaded; the single hash unit
//  sets the pace. After reset a clearing pass zeroes every counter, with
//  req held not ready. A pending result holds the sequencer only at its end.
// ----------------------------------------------------------------------------
`default_nettype none

module counting_bloom_filter #(
	parameter int unsigned NUM_COUNTERS = 1024,
	parameter int unsigned COUNTER_BITS = 8
) (
	input wire logic  clk,
	input wire logic  arst_n,
	cbf_cfg_if.sink   cfg,
	cbf_req_if.sink   req,
	cbf_rsp_if.source rsp
);
	import cbf_pkg::*;

	localparam int unsigned IDX_W = $clog2(NUM_COUNTERS);
	typedef logic [COUNTER_BITS-1:0] counter_t;

	typedef enum logic [4:0] {
		ST_CLR  = 5'b00001,
		ST_IDLE = 5'b00010,
		ST_HASH = 5'b00100,
		ST_UPD  = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

	state_t                 state_q;
	logic [IDX_W-1:0]       clr_q;
	hash_count_t            hash_count_q;
	word_t                  seed_q [MAX_HASHES];
	hash_count_t            n_q;
	logic [SEED_IDX_W-1:0]  seed_idx_q;
	op_t                    op_q;
	element_t               elem_q;
	word_t                  min_q;
	logic                   rsp_valid_q;
	min_count_t             rsp_min_q;
	logic                   rsp_present_q;
	counter_t               rd_data_q;
	counter_t               counter_mem [NUM_COUNTERS];

	logic                   accept;
	logic                   last_seed;
	logic                   hash_start;
	logic [SEED_IDX_W-1:0]  next_seed;
	element_t               hash_elem;
	logic                   hash_done;
	logic [IDX_W-1:0]       hash_index;
	counter_t               upd_value;
	logic                   wr_en;
	logic [IDX_W-1:0]       wr_addr;
	counter_t               wr_data;
	hash_count_t            n_clamped;
	logic                   fin_load;

	assign cfg.ready = 1'b1;
	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;

	always_comb begin
		if (hash_count_q == '0)
			n_clamped = HCNT_W'(1);
		else if (hash_count_q > HCNT_W'(MAX_HASHES))
			n_clamped = HCNT_W'(MAX_HASHES);
		else
			n_clamped = hash_count_q;
	end

	assign last_seed  = ({1'b0, seed_idx_q} == n_q - HCNT_W'(1));
	assign hash_start = (accept && req.op != OP_NONE) || (state_q == ST_UPD && !last_seed);
	assign next_seed  = (state_q == ST_UPD) ? seed_idx_q + SEED_IDX_W'(1) : '0;
	assign hash_elem  = (state_q == ST_UPD) ? elem_q : req.element;

	cbf_hash #(
		.NUM_COUNTERS (NUM_COUNTERS)
	) u_hash (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (hash_start),
		.element (hash_elem),
		.seed    (seed_q[next_seed]),
		.done    (hash_done),
		.index   (hash_index)
	);

	// saturate at both ends
	always_comb begin
		upd_value = rd_data_q;
		if (op_q == OP_INSERT && rd_data_q != '1)
			upd_value = rd_data_q + counter_t'(1);
		else if (op_q == OP_REMOVE && rd_data_q != '0)
			upd_value = rd_data_q - counter_t'(1);
	end

	assign wr_en   = (state_q == ST_CLR) ||
	                 (state_q == ST_UPD && (op_q == OP_INSERT || op_q == OP_REMOVE));
	assign wr_addr = (state_q == ST_CLR) ? clr_q : hash_index;
	assign wr_data = (state_q == ST_CLR) ? '0 : upd_value;

	always_ff @(posedge clk) begin
		if (wr_en)
			counter_mem[wr_addr] <= wr_data;
		if (state_q == ST_HASH && hash_done)
			rd_data_q <= counter_mem[hash_index];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_count_q <= HCNT_W'(MAX_HASHES);
			for (int i = 0; i < MAX_HASHES; i++)
				seed_q[i] <= 32'(i);
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_HASH_COUNT: hash_count_q <= cfg.data[HCNT_W-1:0];
				REG_SEED_ZERO:  seed_q[0]    <= cfg.data;
				REG_SEED_ONE:   seed_q[1]    <= cfg.data;
				REG_SEED_TWO:   seed_q[2]    <= cfg.data;
				REG_SEED_THREE: seed_q[3]    <= cfg.data;
				default: ;
			endcase
		end
	end

	assign fin_load = (state_q == ST_FIN) && (!rsp_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			rsp_valid_q <= fin_load || (rsp_valid_q && !rsp.ready);
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == IDX_W'(NUM_COUNTERS - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE:
					if (accept && req.op != OP_NONE)
						state_q <= ST_HASH;
				ST_HASH:
					if (hash_done)
						state_q <= ST_UPD;
				ST_UPD:
					if (!last_seed)
						state_q <= ST_HASH;
					else if (op_q == OP_CHECK)
						state_q <= ST_FIN;
					else
						state_q <= ST_IDLE;
				ST_FIN:
					if (fin_load)
						state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= req.op;
			elem_q     <= req.element;
			n_q        <= n_clamped;
			seed_idx_q <= '0;
			min_q      <= MIN_START;
		end
		if (state_q == ST_UPD) begin
			seed_idx_q <= next_seed;
			if (32'(rd_data_q) < min_q)
				min_q <= 32'(rd_data_q);
		end
		if (fin_load) begin
			rsp_min_q     <= min_q[MIN_W-1:0];
			rsp_present_q <= (min_q != '0);
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.min_count = rsp_min_q;
	assign rsp.present   = rsp_present_q;

`ifndef SYNTHESIS
	a_done_in_hash: assert property (@(posedge clk) disable iff (!arst_n)
		hash_done |-> state_q == ST_HASH)
		else $error("hash result outside hash wait");

	a_seed_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UPD |-> {1'b0, seed_idx_q} < n_q)
		else $error("seed index beyond hash count");

	a_fin_check_only: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN |-> op_q == OP_CHECK)
		else $error("result pending for a non-check word");
`endif

endmodule

`default_nettype wire
